### hw/rtl/wrp_pkg.sv
package wrp_pkg;

    // One byte of the WAV file as it enters the block.
    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } byte_item_t;

    // One result: a PCM sample or the final parse status.
    typedef struct packed {
        logic               result_kind;
        logic signed [15:0] pcm_sample;
        logic [2:0]         parse_status;
        logic [31:0]        rate_hz;
        logic [30:0]        samples_total;
        logic               final_flag;
    } result_t;

    // Results produced by the front for one accepted byte, in order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    typedef enum logic [2:0] {
        PH_MAGIC = 3'd0,
        PH_HDR   = 3'd1,
        PH_FMT   = 3'd2,
        PH_SKIP  = 3'd3,
        PH_DATA  = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
    localparam logic [2:0] ST_DATA_NO_FMT = 3'd2;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ST_NO_DATA     = 3'd4;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
    localparam logic [3:0]  RIFF_LAST    = 4'd3;
    localparam logic [3:0]  MAGIC_LAST   = 4'd11;
    localparam logic [3:0]  HDR_LAST     = 4'd7;
    localparam logic [3:0]  FMT_LAST     = 4'd15;

    localparam logic [15:0] MONO_CHANNELS = 16'd1;
    localparam logic [15:0] PCM16_BITS    = 16'd16;

endpackage

### hw/rtl/wrp_front.sv
// Byte parser: walks the RIFF structure and produces up to two results per byte.
module wrp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  wrp_pkg::byte_item_t item,
    output wrp_pkg::push_t     push
);

    wrp_pkg::phase_t phase_reg, phase_next, phase_step;
    logic [3:0]  pos_reg, pos_next, pos_step;
    logic [31:0] tag_reg, tag_next, tag_step;
    logic [32:0] left_reg, left_next, left_step;
    logic        fmt_seen_reg, fmt_seen_next, fmt_seen_step;
    logic [15:0] chan_reg, chan_next, chan_step;
    logic [15:0] bits_reg, bits_next, bits_step;
    logic [31:0] rate_reg, rate_next, rate_step;
    logic [7:0]  low_reg, low_next, low_step;
    logic [30:0] count_reg, count_next, count_step;
    logic [2:0]  status_reg, status_next, status_step;

    logic [7:0]  b;
    logic [31:0] tag_shift;
    logic [32:0] left_dec;
    logic [31:0] size;
    logic [32:0] padded;
    logic        sample_emit;
    logic [2:0]  final_status;

    assign b         = item.file_byte;
    assign tag_shift = {tag_reg[23:0], b};
    assign left_dec  = left_reg - 33'd1;
    assign size      = {b, left_reg[23:0]};
    assign padded    = {1'b0, size} + {32'd0, size[0]};

    // Next state of the parser for one byte.
    always_comb
    begin
        phase_step    = phase_reg;
        pos_step      = pos_reg;
        tag_step      = tag_reg;
        left_step     = left_reg;
        fmt_seen_step = fmt_seen_reg;
        chan_step     = chan_reg;
        bits_step     = bits_reg;
        rate_step     = rate_reg;
        low_step      = low_reg;
        count_step    = count_reg;
        status_step   = status_reg;

        case (phase_reg)
            wrp_pkg::PH_MAGIC:
            begin
                tag_step = tag_shift;
                pos_step = pos_reg + 4'd1;
                if (pos_reg == wrp_pkg::RIFF_LAST && tag_shift != wrp_pkg::TAG_RIFF)
                begin
                    status_step = wrp_pkg::ST_BAD_MAGIC;
                    phase_step  = wrp_pkg::PH_DONE;
                end
                else if (pos_reg == wrp_pkg::MAGIC_LAST)
                begin
                    if (tag_shift != wrp_pkg::TAG_WAVE)
                    begin
                        status_step = wrp_pkg::ST_BAD_MAGIC;
                        phase_step  = wrp_pkg::PH_DONE;
                    end
                    else
                    begin
                        phase_step = wrp_pkg::PH_HDR;
                        pos_step   = 4'd0;
                        tag_step   = 32'd0;
                        left_step  = 33'd0;
                    end
                end
            end
            wrp_pkg::PH_HDR:
            begin
                pos_step = pos_reg + 4'd1;
                if (!pos_reg[2])
                begin
                    tag_step = tag_shift;
                    if (pos_reg == 4'd0)
                    begin
                        left_step = 33'd0;
                    end
                end
                else
                begin
                    case (pos_reg[1:0])
                        2'd0:    left_step[7:0]   = b;
                        2'd1:    left_step[15:8]  = b;
                        2'd2:    left_step[23:16] = b;
                        default: left_step[31:24] = b;
                    endcase
                end
                if (pos_reg == wrp_pkg::HDR_LAST)
                begin
                    pos_step = 4'd0;
                    if (tag_reg == wrp_pkg::TAG_FMT)
                    begin
                        if (size < wrp_pkg::FMT_MIN_SIZE)
                        begin
                            status_step = wrp_pkg::ST_UNSUPPORTED;
                            phase_step  = wrp_pkg::PH_DONE;
                        end
                        else
                        begin
                            left_step  = padded;
                            phase_step = wrp_pkg::PH_FMT;
                        end
                    end
                    else if (tag_reg == wrp_pkg::TAG_DATA)
                    begin
                        if (!fmt_seen_reg)
                        begin
                            status_step = wrp_pkg::ST_DATA_NO_FMT;
                            phase_step  = wrp_pkg::PH_DONE;
                        end
                        else if (chan_reg != wrp_pkg::MONO_CHANNELS
                                 || bits_reg != wrp_pkg::PCM16_BITS)
                        begin
                            status_step = wrp_pkg::ST_UNSUPPORTED;
                            phase_step  = wrp_pkg::PH_DONE;
                        end
                        else
                        begin
                            status_step = wrp_pkg::ST_OK;
                            left_step   = {1'b0, size};
                            phase_step  = (size == 32'd0) ? wrp_pkg::PH_DONE
                                                          : wrp_pkg::PH_DATA;
                        end
                    end
                    else
                    begin
                        left_step  = padded;
                        phase_step = (padded == 33'd0) ? wrp_pkg::PH_HDR
                                                       : wrp_pkg::PH_SKIP;
                    end
                end
            end
            wrp_pkg::PH_FMT:
            begin
                case (pos_reg)
                    4'd2:    chan_step[7:0]    = b;
                    4'd3:    chan_step[15:8]   = b;
                    4'd4:    rate_step[7:0]    = b;
                    4'd5:    rate_step[15:8]   = b;
                    4'd6:    rate_step[23:16]  = b;
                    4'd7:    rate_step[31:24]  = b;
                    4'd14:   bits_step[7:0]    = b;
                    4'd15:   bits_step[15:8]   = b;
                    default: chan_step         = chan_reg;
                endcase
                left_step = left_dec;
                pos_step  = pos_reg + 4'd1;
                if (pos_reg == wrp_pkg::FMT_LAST)
                begin
                    fmt_seen_step = 1'b1;
                    pos_step      = 4'd0;
                    phase_step    = (left_dec == 33'd0) ? wrp_pkg::PH_HDR
                                                        : wrp_pkg::PH_SKIP;
                end
            end
            wrp_pkg::PH_SKIP:
            begin
                left_step = left_dec;
                if (left_dec == 33'd0)
                begin
                    phase_step = wrp_pkg::PH_HDR;
                    pos_step   = 4'd0;
                end
            end
            wrp_pkg::PH_DATA:
            begin
                if (!pos_reg[0])
                begin
                    low_step = b;
                end
                else
                begin
                    count_step = count_reg + 31'd1;
                end
                pos_step  = {3'd0, ~pos_reg[0]};
                left_step = left_dec;
                if (left_dec == 33'd0)
                begin
                    phase_step = wrp_pkg::PH_DONE;
                end
            end
            default:
            begin
                phase_step = phase_reg;
            end
        endcase
    end

    // The last byte of a file returns every register to its reset value.
    always_comb
    begin
        phase_next    = phase_step;
        pos_next      = pos_step;
        tag_next      = tag_step;
        left_next     = left_step;
        fmt_seen_next = fmt_seen_step;
        chan_next     = chan_step;
        bits_next     = bits_step;
        rate_next     = rate_step;
        low_next      = low_step;
        count_next    = count_step;
        status_next   = status_step;
        if (item.end_of_file)
        begin
            phase_next    = wrp_pkg::PH_MAGIC;
            pos_next      = 4'd0;
            tag_next      = 32'd0;
            left_next     = 33'd0;
            fmt_seen_next = 1'b0;
            chan_next     = 16'd0;
            bits_next     = 16'd0;
            rate_next     = 32'd0;
            low_next      = 8'd0;
            count_next    = 31'd0;
            status_next   = wrp_pkg::ST_OK;
        end
    end

    // Results for the byte on the input.
    always_comb
    begin
        sample_emit = accept && phase_reg == wrp_pkg::PH_DATA && pos_reg[0];

        case (phase_step)
            wrp_pkg::PH_MAGIC: final_status = wrp_pkg::ST_BAD_MAGIC;
            wrp_pkg::PH_HDR,
            wrp_pkg::PH_FMT,
            wrp_pkg::PH_SKIP:  final_status = wrp_pkg::ST_NO_DATA;
            default:           final_status = status_step;
        endcase

        push.first  = '0;
        push.second = '0;
        push.count  = 2'd0;

        if (sample_emit)
        begin
            push.first.result_kind = wrp_pkg::KIND_SAMPLE;
            push.first.pcm_sample  = {b, low_reg};
        end

        if (accept && item.end_of_file)
        begin
            if (sample_emit)
            begin
                push.second.result_kind   = wrp_pkg::KIND_STATUS;
                push.second.parse_status  = final_status;
                push.second.rate_hz       = rate_step;
                push.second.samples_total = count_step;
                push.second.final_flag    = 1'b1;
                push.count                = 2'd2;
            end
            else
            begin
                push.first.result_kind   = wrp_pkg::KIND_STATUS;
                push.first.parse_status  = final_status;
                push.first.rate_hz       = rate_step;
                push.first.samples_total = count_step;
                push.first.final_flag    = 1'b1;
                push.count               = 2'd1;
            end
        end
        else if (sample_emit)
        begin
            push.count = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= wrp_pkg::PH_MAGIC;
            pos_reg      <= 4'd0;
            tag_reg      <= 32'd0;
            left_reg     <= 33'd0;
            fmt_seen_reg <= 1'b0;
            chan_reg     <= 16'd0;
            bits_reg     <= 16'd0;
            rate_reg     <= 32'd0;
            low_reg      <= 8'd0;
            count_reg    <= 31'd0;
            status_reg   <= wrp_pkg::ST_OK;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            tag_reg      <= tag_next;
            left_reg     <= left_next;
            fmt_seen_reg <= fmt_seen_next;
            chan_reg     <= chan_next;
            bits_reg     <= bits_next;
            rate_reg     <= rate_next;
            low_reg      <= low_next;
            count_reg    <= count_next;
            status_reg   <= status_next;
        end
    end

endmodule

### hw/rtl/wrp_queue.sv
// Result queue: takes up to two results per cycle, gives one per cycle when popped.
module wrp_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wrp_pkg::push_t    push,
    input  logic              pop,
    output logic              not_empty,
    output logic              almost_full,
    output wrp_pkg::result_t  head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    wrp_pkg::result_t  mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [PW-1:0]     wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PW'(1);
    assign not_empty    = count_reg != '0;
    // Two free slots are needed before the front may take another byte.
    assign almost_full  = count_reg > CW'(DEPTH - 2);
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/wrp_back.sv
// Output stage: registers one result and holds it while the consumer stalls.
module wrp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              avail,
    input  wrp_pkg::result_t  head,
    output logic              pop,
    output logic              valid,
    input  logic              stall,
    output wrp_pkg::result_t  item
);

    logic             valid_reg, valid_next;
    wrp_pkg::result_t item_reg;

    assign pop        = avail && (!valid_reg || !stall);
    assign valid_next = pop || (valid_reg && stall);
    assign valid      = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

### hw/rtl/wav_riff_stream_parser.sv
// Channel   Direction  Payload             Handshake
// byte      in         byte_item_t         byte_valid / byte_stall
// result    out        result_t            result_valid / result_stall
//
// One file byte is taken per clock while the queue has room; a result passes through
// the queue and the output register before it can be taken, and a status behind a sample follows it.
// The front parser registers its new state with every accepted byte.
// The result queue (QUEUE_DEPTH entries) stalls the input when fewer than two
// slots are free; the output stage drains one result per cycle unless the consumer stalls.
// Reset is asynchronous and active low; it puts the parser at the start of a file.
module wav_riff_stream_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  wrp_pkg::byte_item_t byte_item,
    output logic                result_valid,
    input  logic                result_stall,
    output wrp_pkg::result_t    result_item
);

    // QUEUE_DEPTH must be a power of two, at least 2.

    logic             accept;
    wrp_pkg::push_t   push;
    logic             q_not_empty;
    logic             q_almost_full;
    logic             q_pop;
    wrp_pkg::result_t q_head;

    // The input is held off only by queue occupancy, never by the parse state.
    assign byte_stall = q_almost_full;
    assign accept     = byte_valid && !byte_stall;

    // Front: RIFF walk, fmt capture and sample assembly.
    wrp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_item),
        .push   (push)
    );

    // Queue between the parser and the output stage.
    wrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .pop         (q_pop),
        .not_empty   (q_not_empty),
        .almost_full (q_almost_full),
        .head        (q_head)
    );

    // Back: output register toward the consumer.
    wrp_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .avail (q_not_empty),
        .head  (q_head),
        .pop   (q_pop),
        .valid (result_valid),
        .stall (result_stall),
        .item  (result_item)
    );

endmodule

### hw/rtl/wrp_checker.sv
// Port-level checks on the result channel.
module wrp_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_stall,
    input wrp_pkg::result_t result_item
);

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result_item))
        else $error("result changed while stalled");

    a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.result_kind == wrp_pkg::KIND_SAMPLE
        |-> result_item.parse_status == wrp_pkg::ST_OK && result_item.rate_hz == 32'd0
            && result_item.samples_total == 31'd0 && !result_item.final_flag)
        else $error("sample result carries status fields");

    a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.result_kind == wrp_pkg::KIND_STATUS
        |-> result_item.final_flag && result_item.pcm_sample == 16'sd0)
        else $error("status result not marked final");

endmodule

bind wav_riff_stream_parser wrp_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);

### sim/tb_top.sv
module tb_top;
    import wrp_pkg::*;

    // With a four-deep result queue the block settles well within this tail.
    localparam int TAIL_CYCLES = 20;

    // Cycles without any accepted item before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;

    // Random bytes queued for each of the three passes.
    localparam int PASS_BYTES = 40;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    byte_item_t byte_item = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    result_t    result_item;

    wav_riff_stream_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // File bytes waiting to be driven, and the results the parser should return.
    byte_item_t pending_bytes[$];
    result_t    expected_results[$];

    // The file under construction and the byte count queued so far.
    logic [7:0] file_buf[$];
    logic [7:0] fmt_template[16];
    int         bytes_queued = 0;

    int send_idle_pct = 22;
    int recv_stall_pct = 66;
    int mismatches = 0;
    int quiet_cycles = 0;

    // Parser state as the testbench tracks it.
    phase_t      walk_phase;
    logic [3:0]  walk_pos;
    logic [31:0] walk_tag;
    logic [32:0] walk_left;
    logic        fmt_seen;
    logic [15:0] fmt_channels;
    logic [15:0] fmt_bits;
    logic [31:0] fmt_rate;
    logic [7:0]  low_byte;
    logic [30:0] sample_count;
    logic [2:0]  file_status;

    // Everything returns to the start of a file, both at reset and after a status.
    function automatic void clear_parser();
        walk_phase   = PH_MAGIC;
        walk_pos     = '0;
        walk_tag     = '0;
        walk_left    = '0;
        fmt_seen     = 1'b0;
        fmt_channels = '0;
        fmt_bits     = '0;
        fmt_rate     = '0;
        low_byte     = '0;
        sample_count = '0;
        file_status  = ST_OK;
    endfunction

    // A failure freezes the parser until the end of the file.
    function automatic void abort_file(input logic [2:0] code);
        file_status = code;
        walk_phase  = PH_DONE;
    endfunction

    // Advances the tracked parser by one byte and queues whatever it emits.
    function automatic void parse_byte(input byte_item_t item);
        logic [7:0]  b;
        logic [31:0] size_field;
        result_t     res;
        b = item.file_byte;
        case (walk_phase)
            PH_MAGIC:
            begin
                // The last four bytes seen are kept; RIFF sits at 0..3, WAVE at 8..11.
                walk_tag = {walk_tag[23:0], b};
                if (walk_pos == RIFF_LAST && walk_tag != TAG_RIFF)
                    abort_file(ST_BAD_MAGIC);
                else if (walk_pos == MAGIC_LAST)
                begin
                    if (walk_tag != TAG_WAVE)
                        abort_file(ST_BAD_MAGIC);
                    else
                    begin
                        walk_phase = PH_HDR;
                        walk_pos   = '0;
                        walk_tag   = '0;
                        walk_left  = '0;
                    end
                end
                else
                    walk_pos = walk_pos + 4'd1;
            end
            PH_HDR:
            begin
                // Tag arrives in reading order, the size little-endian.
                if (walk_pos < 4)
                begin
                    walk_tag = {walk_tag[23:0], b};
                    if (walk_pos == 0)
                        walk_left = '0;
                end
                else
                    walk_left = walk_left | (33'(b) << (8 * (walk_pos - 4)));
                if (walk_pos == HDR_LAST)
                begin
                    size_field = walk_left[31:0];
                    walk_pos   = '0;
                    if (walk_tag == TAG_FMT)
                    begin
                        if (size_field < FMT_MIN_SIZE)
                            abort_file(ST_UNSUPPORTED);
                        else
                        begin
                            walk_left  = {1'b0, size_field} + size_field[0];
                            walk_phase = PH_FMT;
                        end
                    end
                    else if (walk_tag == TAG_DATA)
                    begin
                        if (!fmt_seen)
                            abort_file(ST_DATA_NO_FMT);
                        else if (fmt_channels != MONO_CHANNELS || fmt_bits != PCM16_BITS)
                            abort_file(ST_UNSUPPORTED);
                        else
                        begin
                            file_status = ST_OK;
                            walk_left   = {1'b0, size_field};
                            walk_phase  = (size_field == 0) ? PH_DONE : PH_DATA;
                        end
                    end
                    else
                    begin
                        // Unknown chunk: skip the body and its pad byte.
                        walk_left  = {1'b0, size_field} + size_field[0];
                        walk_phase = (walk_left == 0) ? PH_HDR : PH_SKIP;
                    end
                end
                else
                    walk_pos = walk_pos + 4'd1;
            end
            PH_FMT:
            begin
                // Body offsets: channels at 2..3, rate at 4..7, bits per sample at 14..15.
                case (walk_pos)
                    4'd2: fmt_channels[7:0] = b;
                    4'd3: fmt_channels[15:8] = b;
                    4'd4, 4'd5, 4'd6, 4'd7: fmt_rate[8 * (walk_pos - 4) +: 8] = b;
                    4'd14: fmt_bits[7:0] = b;
                    4'd15: fmt_bits[15:8] = b;
                    default: ;
                endcase
                walk_left = walk_left - 33'd1;
                if (walk_pos == FMT_LAST)
                begin
                    fmt_seen   = 1'b1;
                    walk_pos   = '0;
                    walk_phase = (walk_left == 0) ? PH_HDR : PH_SKIP;
                end
                else
                    walk_pos = walk_pos + 4'd1;
            end
            PH_SKIP:
            begin
                walk_left = walk_left - 33'd1;
                if (walk_left == 0)
                begin
                    walk_phase = PH_HDR;
                    walk_pos   = '0;
                end
            end
            PH_DATA:
            begin
                // Even bytes are held, odd bytes complete a little-endian sample.
                if (!walk_pos[0])
                    low_byte = b;
                else
                begin
                    res             = '0;
                    res.result_kind = KIND_SAMPLE;
                    res.pcm_sample  = {b, low_byte};
                    expected_results.push_back(res);
                    sample_count = sample_count + 31'd1;
                end
                walk_pos  = {3'b000, ~walk_pos[0]};
                walk_left = walk_left - 33'd1;
                if (walk_left == 0)
                    walk_phase = PH_DONE;
            end
            default: ;
        endcase

        if (item.end_of_file)
        begin
            res             = '0;
            res.result_kind = KIND_STATUS;
            case (walk_phase)
                PH_MAGIC:                  res.parse_status = ST_BAD_MAGIC;
                PH_HDR, PH_FMT, PH_SKIP:   res.parse_status = ST_NO_DATA;
                default:                   res.parse_status = file_status;
            endcase
            res.rate_hz       = fmt_rate;
            res.samples_total = sample_count;
            res.final_flag    = 1'b1;
            expected_results.push_back(res);
            clear_parser();
        end
    endfunction

    // File construction: tags go out in reading order, numbers little-endian.
    task automatic add_tag(input logic [31:0] tag_value);
        for (int i = 3; i >= 0; i--)
            file_buf.push_back(tag_value[8 * i +: 8]);
    endtask

    task automatic add_le16(input logic [15:0] value);
        file_buf.push_back(value[7:0]);
        file_buf.push_back(value[15:8]);
    endtask

    task automatic add_le32(input logic [31:0] value);
        for (int i = 0; i < 4; i++)
            file_buf.push_back(value[8 * i +: 8]);
    endtask

    task automatic add_riff_head();
        add_tag(TAG_RIFF);
        add_le32($urandom);
        add_tag(TAG_WAVE);
    endtask

    // Sets the 16 bytes a fmt chunk body starts with; the PCM format tag is 1.
    task automatic set_format(input logic [15:0] channels, input logic [31:0] rate,
                              input logic [15:0] bits);
        fmt_template[0] = 8'h01;
        fmt_template[1] = 8'h00;
        fmt_template[2] = channels[7:0];
        fmt_template[3] = channels[15:8];
        for (int i = 0; i < 4; i++)
            fmt_template[4 + i] = rate[8 * i +: 8];
        for (int i = 8; i < 14; i++)
            fmt_template[i] = 8'($urandom);
        fmt_template[14] = bits[7:0];
        fmt_template[15] = bits[15:8];
    endtask

    // A chunk header followed by body_len bytes; the pad byte follows only a
    // complete odd body. A fmt body takes its first bytes from the template.
    task automatic add_chunk(input logic [31:0] chunk_tag, input logic [31:0] size_field,
                             input int body_len);
        add_tag(chunk_tag);
        add_le32(size_field);
        for (int i = 0; i < body_len; i++)
            file_buf.push_back((chunk_tag == TAG_FMT && i < 16) ? fmt_template[i]
                                                                : 8'($urandom));
        if (body_len == size_field && size_field[0])
            file_buf.push_back(8'($urandom));
    endtask

    // Queues the first keep bytes of the file, marking the last as end of file.
    task automatic send_file(input int keep);
        byte_item_t item;
        for (int i = 0; i < keep; i++)
        begin
            item.file_byte   = file_buf[i];
            item.end_of_file = (i == keep - 1);
            pending_bytes.push_back(item);
        end
        bytes_queued += keep;
        file_buf.delete();
    endtask

    // Mostly well-formed files with random content and random chunk layout;
    // some are noise, some have broken magic, some are cut short.
    task automatic add_random_file();
        int          pick;
        int          keep;
        int          body_len;
        logic [31:0] size_field;
        pick = $urandom_range(99);
        if (pick < 8)
            repeat ($urandom_range(1, 20)) file_buf.push_back(8'($urandom));
        else
        begin
            add_riff_head();
            if ($urandom_range(19) == 0)
                file_buf[$urandom_range(11)] = 8'($urandom);
            repeat ($urandom_range(2))
            begin
                size_field = $urandom_range(5);
                add_chunk($urandom, size_field, size_field);
            end
            if ($urandom_range(99) < 85)
            begin
                set_format(($urandom_range(9) == 0) ? 16'($urandom) : MONO_CHANNELS,
                           $urandom,
                           ($urandom_range(9) == 0) ? 16'($urandom) : PCM16_BITS);
                pick = $urandom_range(9);
                if (pick < 8)
                    size_field = FMT_MIN_SIZE;
                else if (pick == 8)
                    size_field = $urandom_range(17, 20);
                else
                    size_field = $urandom_range(15);
                add_chunk(TAG_FMT, size_field, size_field);
                if ($urandom_range(4) == 0)
                    add_chunk($urandom, $urandom_range(3), 0);
            end
            if ($urandom_range(99) < 90)
            begin
                if ($urandom_range(19) == 0)
                begin
                    // A size far beyond the file: end of file stops the data.
                    size_field = $urandom | 32'h8000_0000;
                    body_len   = $urandom_range(1, 12);
                end
                else
                begin
                    size_field = $urandom_range(16);
                    body_len   = size_field;
                end
                add_chunk(TAG_DATA, size_field, body_len);
            end
            repeat ($urandom_range(3)) file_buf.push_back(8'($urandom));
        end
        keep = file_buf.size();
        if ($urandom_range(99) < 12)
            keep = $urandom_range(1, keep);
        send_file(keep);
    endtask

    initial
    begin
        int target;
        clear_parser();

        // Clean mono 16-bit file whose samples hit both ends of the range.
        add_riff_head();
        set_format(MONO_CHANNELS, 32'd44100, PCM16_BITS);
        add_chunk(TAG_FMT, FMT_MIN_SIZE, 16);
        add_chunk(TAG_DATA, 32'd8, 0);
        add_le16(16'h8000);
        add_le16(16'h7FFF);
        add_le16(16'h0000);
        add_le16(16'hFFFF);
        send_file(file_buf.size());

        // Wrong RIFF tag, then wrong WAVE tag.
        add_tag(32'h5249_4658);
        add_le32($urandom);
        add_tag(TAG_WAVE);
        send_file(file_buf.size());
        add_tag(TAG_RIFF);
        add_le32($urandom);
        add_tag(32'h5741_5658);
        send_file(file_buf.size());

        // A file of one byte, and one that ends inside the RIFF size.
        file_buf.push_back(8'h52);
        send_file(1);
        add_tag(TAG_RIFF);
        add_le16(16'hFFFF);
        file_buf.push_back(8'hFF);
        send_file(file_buf.size());

        // Data chunk with no format seen yet.
        add_riff_head();
        add_chunk(TAG_DATA, 32'd4, 4);
        send_file(file_buf.size());

        // Stereo, then 8-bit: both unsupported.
        add_riff_head();
        set_format(16'd2, 32'd48000, PCM16_BITS);
        add_chunk(TAG_FMT, FMT_MIN_SIZE, 16);
        add_chunk(TAG_DATA, 32'd4, 4);
        send_file(file_buf.size());
        add_riff_head();
        set_format(MONO_CHANNELS, 32'd8000, 16'd8);
        add_chunk(TAG_FMT, FMT_MIN_SIZE, 16);
        add_chunk(TAG_DATA, 32'd4, 4);
        send_file(file_buf.size());

        // A fmt chunk whose size field is below 16 bytes fails.
        add_riff_head();
        set_format(MONO_CHANNELS, 32'd22050, PCM16_BITS);
        add_chunk(TAG_FMT, 32'd14, 14);
        add_chunk(TAG_DATA, 32'd4, 4);
        send_file(file_buf.size());

        // A fmt body cut off by end of file: no data was reached.
        add_riff_head();
        add_chunk(TAG_FMT, FMT_MIN_SIZE, 16);
        send_file(file_buf.size() - 6);

        // Odd unknown chunk and odd fmt with pad bytes, odd data whose trailing
        // byte is dropped, and bytes after the data that are ignored.
        add_riff_head();
        add_chunk(32'h4C49_5354, 32'd3, 3);
        set_format(MONO_CHANNELS, 32'd11025, PCM16_BITS);
        add_chunk(TAG_FMT, 32'd17, 17);
        add_chunk(TAG_DATA, 32'd5, 5);
        add_chunk(TAG_DATA, 32'd4, 4);
        send_file(file_buf.size());

        // Empty data chunk with a zero rate, followed by ignored bytes.
        add_riff_head();
        set_format(MONO_CHANNELS, 32'd0, PCM16_BITS);
        add_chunk(TAG_FMT, 32'd18, 18);
        add_chunk(TAG_DATA, 32'd0, 0);
        add_le16(16'($urandom));
        send_file(file_buf.size());

        // No data chunk at all; an empty unknown chunk goes straight to the next header.
        add_riff_head();
        add_chunk(TAG_FMT, FMT_MIN_SIZE, 16);
        add_chunk(32'h4C49_5354, 32'd0, 0);
        add_chunk(32'h4C49_5354, 32'd2, 2);
        send_file(file_buf.size());

        // Oversized data cut by end of file on a high byte: sample and status together.
        add_riff_head();
        set_format(MONO_CHANNELS, 32'hFFFF_FFFF, PCM16_BITS);
        add_chunk(TAG_FMT, FMT_MIN_SIZE, 16);
        add_chunk(TAG_DATA, 32'hFFFF_FFFF, 6);
        send_file(file_buf.size());

        // Largest odd fmt size, ending while its body is skipped.
        add_riff_head();
        add_chunk(TAG_FMT, 32'hFFFF_FFFF, 20);
        send_file(file_buf.size());

        // End of file inside a chunk header.
        add_riff_head();
        add_chunk(TAG_FMT, FMT_MIN_SIZE, 16);
        add_tag(TAG_DATA);
        add_le16(16'h0004);
        send_file(file_buf.size());

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Three passes: sender light and receiver heavy, the reverse, then no idling.
        for (int p = 0; p < 3; p++)
        begin
            while (pending_bytes.size() != 0)
                @(posedge clk);
            @(negedge clk);
            send_idle_pct  = (p == 0) ? 22 : (p == 1) ? 66 : 0;
            recv_stall_pct = (p == 0) ? 66 : (p == 1) ? 22 : 0;
            target = bytes_queued + PASS_BYTES;
            while (bytes_queued < target)
                add_random_file();
        end

        while (pending_bytes.size() != 0 || byte_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Driver: an accepted byte is fed to the tracked parser, then the next byte
    // is offered unless the sender decides to idle. A stalled byte is held.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_item  <= '0;
            clear_parser();
        end
        else
        begin
            if (byte_valid && !byte_stall)
                parse_byte(byte_item);
            if (!byte_valid || !byte_stall)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    byte_valid <= 1'b1;
                    byte_item  <= pending_bytes.pop_front();
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // Monitor: every accepted result is checked against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin : result_check
        result_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind %0d pcm %0d status %0d",
                                 result_item.result_kind, result_item.pcm_sample,
                                 result_item.parse_status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_item.result_kind !== want.result_kind
                        || result_item.pcm_sample !== want.pcm_sample
                        || result_item.parse_status !== want.parse_status
                        || result_item.rate_hz !== want.rate_hz
                        || result_item.samples_total !== want.samples_total
                        || result_item.final_flag !== want.final_flag)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result mismatch: expected kind %0d pcm %0d status %0d",
                                     want.result_kind, want.pcm_sample, want.parse_status,
                                     " rate %0d total %0d final %0d",
                                     want.rate_hz, want.samples_total, want.final_flag);
                            $display("                 got      kind %0d pcm %0d status %0d",
                                     result_item.result_kind, result_item.pcm_sample,
                                     result_item.parse_status,
                                     " rate %0d total %0d final %0d",
                                     result_item.rate_hz, result_item.samples_total,
                                     result_item.final_flag);
                        end
                    end
                end
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: a long stretch with no item moving on either channel means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
